[rtl/core/adsr_envelope_generator_macros.svh]
// Assertion macros for the envelope generator checker.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// Clocked check, masked while reset is held.
`define ADSR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("adsr check failed");

// Clocked check that also runs through reset.
`define ADSR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("adsr reset check failed");

`endif

[rtl/core/adsr_pkg.sv]
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int DAC_BITS            = 12;
    localparam int LEVEL_FRACTION_BITS = 24;

    // Q1.F level
    localparam int LEVEL_W = LEVEL_FRACTION_BITS + 1;
    // widths fixed by the register map
    localparam int CFG_LEVEL_W  = 25;
    localparam int CFG_MULT_W   = 16;
    localparam int CFG_MARGIN_W = 21;
    localparam int CFG_DATA_W   = 25;
    localparam int CFG_INDEX_W  = 3;

    // headroom for level sums
    localparam int ACC_W  = ((LEVEL_W > CFG_LEVEL_W) ? LEVEL_W : CFG_LEVEL_W) + 1;
    localparam int MULT_W = 16;
    localparam int PROD_W = LEVEL_W + MULT_W;
    localparam int CODE_W = PROD_W - LEVEL_FRACTION_BITS;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};
    localparam logic [MULT_W-1:0]  DAC_MAX    = MULT_W'((1 << DAC_BITS) - 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_INC  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_MULT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_MUL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN      = 3'd4;

    // register reset values
    localparam logic [CFG_LEVEL_W-1:0]  RST_ATTACK_INC  = 25'd2181;
    localparam logic [CFG_MULT_W-1:0]   RST_DECAY_MULT  = 16'd65470;
    localparam logic [CFG_LEVEL_W-1:0]  RST_SUSTAIN     = 25'd8388608;
    localparam logic [CFG_MULT_W-1:0]   RST_RELEASE_MUL = 16'd65470;
    localparam logic [CFG_MARGIN_W-1:0] RST_MARGIN      = 21'd16777;

    // envelope phase, as reported on the result channel
    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_STOPPED = 3'd4
    } phase_t;

endpackage

[rtl/core/adsr_envelope_generator.sv]
`timescale 1ns / 1ps
// ADSR envelope generator.
// Input channel (s_valid/s_ready/s_gate_level): one transfer per envelope
// tick, carrying the note gate for that tick. A rising gate restarts attack
// from the current level; a low gate sends any active phase to release.
// Result channel (m_valid/m_ready/m_dac_code/m_phase_now): one transfer per
// tick, the level scaled by 4095 (truncated) and the phase after the tick.
// Config port (cfg_wr_en/cfg_index/cfg_wr_data): single-cycle register write,
// index 0..4; other indexes are dropped. Write only while the block is idle.
// Sequencing: one shared 25x16 multiplier, reused by decay, release and DAC
// scaling under a small sequencer. A tick runs the decay multiply and add
// if decay is active, a hold step, the release multiply and finish if release
// is active, then the DAC multiply and the output step; s_ready rises with
// m_valid, so the block takes no new tick until the last result is registered.
// Reset: level 0, phase stopped, gate low, registers to their defaults.
// Stall: the result register holds while m_ready is low; the block may take
// the next tick meanwhile but waits in its last step until the result slot
// frees up.

module adsr_envelope_generator
    import adsr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_gate_level,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DAC_BITS-1:0]     m_dac_code,
    output logic [2:0]              m_phase_now
);

    // sequencer, one-hot
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DECAY_MUL = 8'b0000_0010,
        ST_DECAY_ADD = 8'b0000_0100,
        ST_HOLD      = 8'b0000_1000,
        ST_REL_MUL   = 8'b0001_0000,
        ST_REL_FIN   = 8'b0010_0000,
        ST_DAC_MUL   = 8'b0100_0000,
        ST_OUT       = 8'b1000_0000
    } seq_t;

    seq_t state_reg, state_next;

    // configuration
    logic [CFG_LEVEL_W-1:0]  attack_inc_reg;
    logic [CFG_MULT_W-1:0]   decay_mult_reg;
    logic [CFG_LEVEL_W-1:0]  sustain_reg;
    logic [CFG_MULT_W-1:0]   release_mult_reg;
    logic [CFG_MARGIN_W-1:0] margin_reg;

    // envelope state, also the working value during a tick
    logic [LEVEL_W-1:0] level_reg, level_next;
    phase_t             phase_reg, phase_next;
    logic               gate_reg, gate_next;
    logic               below_sus_reg, below_sus_next;

    // shared multiplier
    logic [LEVEL_W-1:0] mul_a;
    logic [MULT_W-1:0]  mul_b;
    logic [PROD_W-1:0]  prod_reg;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [DAC_BITS-1:0] dac_reg, dac_next;
    phase_t              out_phase_reg, out_phase_next;

    // derived values
    logic [LEVEL_W-1:0] sus;
    logic [ACC_W-1:0]   sus_margin;
    logic [ACC_W-1:0]   attack_sum;
    logic [LEVEL_W-1:0] prod_q16;
    logic [ACC_W-1:0]   decay_up;
    logic [LEVEL_W-1:0] decay_lvl;
    logic [CODE_W-1:0]  code_wide;
    logic               rise;
    phase_t             start_phase;
    logic               out_free;

    // sustain saturated to full scale
    assign sus = (ACC_W'(sustain_reg) > ACC_W'(FULL_SCALE)) ? FULL_SCALE
                                                              : LEVEL_W'(sustain_reg);
    assign sus_margin = ACC_W'(sus) + ACC_W'(margin_reg);
    assign prod_q16   = prod_reg[PROD_W-1:MULT_W];
    assign decay_up   = ACC_W'(sus) + ACC_W'(prod_q16);
    assign decay_lvl  = below_sus_reg ? (sus - prod_q16) : LEVEL_W'(decay_up);
    assign code_wide  = prod_reg[PROD_W-1:LEVEL_FRACTION_BITS];

    assign rise        = s_gate_level & ~gate_reg;
    assign start_phase = rise ? PH_ATTACK : phase_reg;
    assign attack_sum  = ACC_W'(level_reg) + ACC_W'(attack_inc_reg);
    assign out_free    = ~m_valid_reg | m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_dac_code  = dac_reg;
    assign m_phase_now = out_phase_reg;

    // operand select for the shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_DECAY_MUL: begin
                mul_a = (level_reg < sus) ? (sus - level_reg) : (level_reg - sus);
                mul_b = decay_mult_reg;
            end
            ST_REL_MUL: begin
                mul_a = level_reg;
                mul_b = release_mult_reg;
            end
            default: begin
                mul_a = level_reg;
                mul_b = DAC_MAX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        phase_next     = phase_reg;
        gate_next      = gate_reg;
        below_sus_next = below_sus_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        dac_next       = dac_reg;
        out_phase_next = out_phase_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    gate_next  = s_gate_level;
                    phase_next = start_phase;
                    state_next = ST_HOLD;
                    // attack step
                    if (start_phase == PH_ATTACK) begin
                        if (attack_sum >= ACC_W'(FULL_SCALE)) begin
                            level_next = FULL_SCALE;
                            phase_next = PH_DECAY;
                            state_next = ST_DECAY_MUL;
                        end else begin
                            level_next = LEVEL_W'(attack_sum);
                        end
                    end else if (start_phase == PH_DECAY) begin
                        state_next = ST_DECAY_MUL;
                    end
                end
            end
            ST_DECAY_MUL: begin
                below_sus_next = (level_reg < sus);
                state_next     = ST_DECAY_ADD;
            end
            ST_DECAY_ADD: begin
                level_next = decay_lvl;
                if (ACC_W'(decay_lvl) <= sus_margin) begin
                    phase_next = PH_SUSTAIN;
                end
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (phase_reg == PH_SUSTAIN) begin
                    level_next = sus;
                end
                if (!gate_reg && (phase_reg == PH_ATTACK || phase_reg == PH_DECAY ||
                                  phase_reg == PH_SUSTAIN)) begin
                    phase_next = PH_RELEASE;
                    state_next = ST_REL_MUL;
                end else if (phase_reg == PH_RELEASE) begin
                    state_next = ST_REL_MUL;
                end else begin
                    state_next = ST_DAC_MUL;
                end
            end
            ST_REL_MUL: begin
                state_next = ST_REL_FIN;
            end
            ST_REL_FIN: begin
                if (ACC_W'(prod_q16) <= ACC_W'(margin_reg)) begin
                    level_next = '0;
                    phase_next = PH_STOPPED;
                end else begin
                    level_next = prod_q16;
                end
                state_next = ST_DAC_MUL;
            end
            ST_DAC_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_phase_next = phase_reg;
                    dac_next = (code_wide > CODE_W'(DAC_MAX)) ? DAC_BITS'(DAC_MAX)
                                                               : code_wide[DAC_BITS-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            phase_reg     <= PH_STOPPED;
            gate_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_phase_reg <= PH_STOPPED;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            phase_reg     <= phase_next;
            gate_reg      <= gate_next;
            m_valid_reg   <= m_valid_next;
            out_phase_reg <= out_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        below_sus_reg <= below_sus_next;
        dac_reg       <= dac_next;
    end

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_inc_reg   <= RST_ATTACK_INC;
            decay_mult_reg   <= RST_DECAY_MULT;
            sustain_reg      <= RST_SUSTAIN;
            release_mult_reg <= RST_RELEASE_MUL;
            margin_reg       <= RST_MARGIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ATTACK_INC:  attack_inc_reg   <= cfg_wr_data[CFG_LEVEL_W-1:0];
                REG_DECAY_MULT:  decay_mult_reg   <= cfg_wr_data[CFG_MULT_W-1:0];
                REG_SUSTAIN:     sustain_reg      <= cfg_wr_data[CFG_LEVEL_W-1:0];
                REG_RELEASE_MUL: release_mult_reg <= cfg_wr_data[CFG_MULT_W-1:0];
                REG_MARGIN:      margin_reg       <= cfg_wr_data[CFG_MARGIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/adsr_checker.sv]
`timescale 1ns / 1ps
`include "adsr_envelope_generator_macros.svh"

module adsr_checker
    import adsr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [DAC_BITS-1:0] m_dac_code,
    input logic [2:0]          m_phase_now
);

    // result held until taken
    `ADSR_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_dac_code) && $stable(m_phase_now))

    // no result straight out of reset
    `ADSR_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // taking a tick makes the block busy
    `ADSR_ASSERT(a_busy_after_take, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // a stopped envelope sits at zero
    `ADSR_ASSERT(a_stopped_zero, aclk, aresetn, m_valid && m_phase_now == PH_STOPPED |-> m_dac_code == '0)

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_dac_code  (m_dac_code),
    .m_phase_now (m_phase_now)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import adsr_pkg::*;

    localparam int CLK_HALF_NS     = 2;
    localparam int RESET_CYCLES    = 6;
    localparam int RUN_LIMIT_NS    = 2_000_000;   // far above a slow clean run
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 16;          // longer than the longest tick
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_TICKS   = 60;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_COUNT     = 5;

    // indexes above the last register decode to nothing
    localparam logic [CFG_INDEX_W-1:0]  REG_SPARE_FIRST = REG_MARGIN + 3'd1;
    localparam logic [CFG_LEVEL_W-1:0]  LEVEL_REG_MAX   = '1;
    localparam logic [CFG_MULT_W-1:0]   MULT_MAX        = '1;
    localparam logic [CFG_MULT_W-1:0]   MULT_HALF       = 16'd32768;
    localparam logic [CFG_MULT_W-1:0]   MULT_BRISK      = 16'd40000;
    localparam logic [CFG_MULT_W-1:0]   MULT_FAST_TOP   = 16'd60000;
    localparam logic [CFG_MARGIN_W-1:0] MARGIN_MAX      = 21'd1048576;

    typedef struct packed {
        logic [DAC_BITS-1:0] dac_code;
        phase_t              phase;
    } envelope_point_t;

    // receiver behaviour, re-chosen after a random run length
    typedef enum logic [1:0] {
        SINK_OPEN,      // always ready
        SINK_COIN,      // ready half the time
        SINK_SPARSE,    // ready with probability one in five
        SINK_CHOPPY     // ready while bit 2 of the run counter is set
    } sink_mode_t;

    // Envelope predictor plus the queue of envelope points still owed by the block.
    class envelope_scoreboard;
        logic [CFG_LEVEL_W-1:0]  attack_inc;
        logic [CFG_MULT_W-1:0]   decay_mult;
        logic [CFG_LEVEL_W-1:0]  sustain;
        logic [CFG_MULT_W-1:0]   release_mult;
        logic [CFG_MARGIN_W-1:0] margin;
        logic [LEVEL_W-1:0]      env_level;
        phase_t                  env_phase;
        logic                    gate_prev;
        envelope_point_t         owed_points[$];
        int unsigned             ticks_noted;
        int unsigned             points_checked;
        int unsigned             mismatches;
        int unsigned             phase_hits[PHASE_COUNT];

        function new();
            attack_inc     = RST_ATTACK_INC;
            decay_mult     = RST_DECAY_MULT;
            sustain        = RST_SUSTAIN;
            release_mult   = RST_RELEASE_MUL;
            margin         = RST_MARGIN;
            env_level      = '0;
            env_phase      = PH_STOPPED;
            gate_prev      = 1'b0;
            ticks_noted    = 0;
            points_checked = 0;
            mismatches     = 0;
            foreach (phase_hits[i]) phase_hits[i] = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ATTACK_INC:  attack_inc   = data[CFG_LEVEL_W-1:0];
                REG_DECAY_MULT:  decay_mult   = data[CFG_MULT_W-1:0];
                REG_SUSTAIN:     sustain      = data[CFG_LEVEL_W-1:0];
                REG_RELEASE_MUL: release_mult = data[CFG_MULT_W-1:0];
                REG_MARGIN:      margin       = data[CFG_MARGIN_W-1:0];
                default: ;
            endcase
        endfunction

        // One tick. Phases are evaluated in order so a phase that ends
        // falls straight through to the next within the same tick.
        function envelope_point_t advance_envelope(logic gate);
            logic [LEVEL_W:0]            sum;
            logic [LEVEL_W-1:0]          sus;
            logic [PROD_W-1:0]           prod;
            logic [LEVEL_W+DAC_BITS-1:0] scaled;
            envelope_point_t             point;

            sus = (sustain > FULL_SCALE) ? FULL_SCALE : sustain[LEVEL_W-1:0];
            if (gate && !gate_prev)
                env_phase = PH_ATTACK;
            gate_prev = gate;

            if (env_phase == PH_ATTACK) begin
                sum = (LEVEL_W+1)'(env_level) + (LEVEL_W+1)'(attack_inc);
                if (sum >= FULL_SCALE) begin
                    env_level = FULL_SCALE;
                    env_phase = PH_DECAY;
                end else begin
                    env_level = sum[LEVEL_W-1:0];
                end
            end
            if (env_phase == PH_DECAY) begin
                // approach from above normally, from below when sustain was raised
                if (env_level >= sus) begin
                    prod      = PROD_W'(env_level - sus) * PROD_W'(decay_mult);
                    env_level = sus + prod[PROD_W-1:MULT_W];
                end else begin
                    prod      = PROD_W'(sus - env_level) * PROD_W'(decay_mult);
                    env_level = sus - prod[PROD_W-1:MULT_W];
                end
                sum = (LEVEL_W+1)'(sus) + (LEVEL_W+1)'(margin);
                if (env_level <= sum)
                    env_phase = PH_SUSTAIN;
            end
            if (env_phase == PH_SUSTAIN)
                env_level = sus;
            if (env_phase <= PH_SUSTAIN && !gate)
                env_phase = PH_RELEASE;
            if (env_phase == PH_RELEASE) begin
                prod      = PROD_W'(env_level) * PROD_W'(release_mult);
                env_level = prod[PROD_W-1:MULT_W];
                if (env_level <= margin) begin
                    env_phase = PH_STOPPED;
                    env_level = '0;
                end
            end

            scaled = (LEVEL_W+DAC_BITS)'(env_level) * (LEVEL_W+DAC_BITS)'(DAC_MAX);
            scaled = scaled >> LEVEL_FRACTION_BITS;
            if (scaled > DAC_MAX)
                scaled = (LEVEL_W+DAC_BITS)'(DAC_MAX);
            point.dac_code = scaled[DAC_BITS-1:0];
            point.phase    = env_phase;
            return point;
        endfunction

        function void note_tick(logic gate);
            envelope_point_t point;
            point = advance_envelope(gate);
            owed_points.push_back(point);
            phase_hits[point.phase]++;
            ticks_noted++;
        endfunction

        function void check_result(logic [DAC_BITS-1:0] code, logic [2:0] ph);
            envelope_point_t want;
            if (owed_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with nothing owed: dac_code %0d phase %0d",
                             $realtime, code, ph);
                return;
            end
            want = owed_points.pop_front();
            points_checked++;
            if (code !== want.dac_code || ph !== want.phase) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] point %0d: dac_code exp %0d got %0d, phase exp %0d got %0d",
                             $realtime, points_checked, want.dac_code, code, want.phase, ph);
            end
        endfunction

        function int unsigned pending();
            return owed_points.size();
        endfunction

        function void count_leftovers();
            if (owed_points.size() != 0) begin
                $display("%0d envelope points never delivered", owed_points.size());
                mismatches += owed_points.size();
            end
        endfunction
    endclass

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic                   s_gate_level = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [DAC_BITS-1:0]    m_dac_code;
    logic [2:0]             m_phase_now;

    envelope_scoreboard envelope_sb;
    sink_mode_t         sink_mode    = SINK_OPEN;
    int unsigned        sink_count   = 0;
    int unsigned        burst_left   = 0;
    bit                 pacing_on    = 1'b0;
    int unsigned        settings_run = 0;

    adsr_envelope_generator u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gate_level (s_gate_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dac_code   (m_dac_code),
        .m_phase_now  (m_phase_now)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // Receiver stalls. Mode and its run length are drawn together so that
    // long open stretches alternate with heavy back-pressure.
    always @(posedge aclk) begin
        if (sink_count == 0) begin
            sink_mode  <= sink_mode_t'($urandom_range(0, 3));
            sink_count <= $urandom_range(16, 80);
        end else begin
            sink_count <= sink_count - 1;
        end
        case (sink_mode)
            SINK_OPEN:   m_ready <= 1'b1;
            SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
            default:     m_ready <= sink_count[2];
        endcase
    end

    // Result side: values read here are the ones the block saw at this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            envelope_sb.check_result(m_dac_code, m_phase_now);
    end

    // Present one tick and hold it until the transfer happens.
    task automatic send_tick(input logic gate);
        s_valid      <= 1'b1;
        s_gate_level <= gate;
        do @(posedge aclk); while (!s_ready);
        envelope_sb.note_tick(gate);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Sender works in bursts; a zero gap keeps valid high across the boundary.
    task automatic paced_tick(input logic gate);
        send_tick(gate);
        if (pacing_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and wait for every owed point, then let the pipeline settle.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (envelope_sb.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; close_cfg drops it after a series of writes.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        envelope_sb.write_reg(idx, data);
    endtask

    task automatic close_cfg();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] attack,
                                 input logic [CFG_DATA_W-1:0] decay,
                                 input logic [CFG_DATA_W-1:0] sus,
                                 input logic [CFG_DATA_W-1:0] rel,
                                 input logic [CFG_DATA_W-1:0] marg);
        write_reg(REG_ATTACK_INC, attack);
        write_reg(REG_DECAY_MULT, decay);
        write_reg(REG_SUSTAIN, sus);
        write_reg(REG_RELEASE_MUL, rel);
        write_reg(REG_MARGIN, marg);
        close_cfg();
        settings_run++;
    endtask

    // Mostly values that move the envelope within a segment, sometimes the extremes.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_DATA_W-1:0] lo,
                                                           input logic [CFG_DATA_W-1:0] hi,
                                                           input logic [CFG_DATA_W-1:0] fast_lo,
                                                           input logic [CFG_DATA_W-1:0] fast_hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return CFG_DATA_W'($urandom_range(fast_hi, fast_lo));
        endcase
    endfunction

    // Notes: gate held for a while, then released; about one in five is gate noise.
    task automatic random_segment(input int unsigned ticks);
        int unsigned sent;
        int unsigned hold;
        int unsigned rest;
        sent = 0;
        while (sent < ticks) begin
            if ($urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 10);
                repeat (hold) paced_tick(1'($urandom_range(0, 1)));
                sent += hold;
            end else begin
                hold = $urandom_range(1, 40);
                rest = $urandom_range(1, 25);
                repeat (hold) paced_tick(1'b1);
                repeat (rest) paced_tick(1'b0);
                sent += hold + rest;
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] sus_pick;

        envelope_sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: idle tick while stopped, a slow attack step, then
        // a release that drops under the margin at once.
        paced_tick(1'b0);
        paced_tick(1'b1);
        paced_tick(1'b0);
        drain_results();

        // Full-scale attack step, zero decay and release factors, zero margin,
        // sustain register beyond full scale (must saturate to 1.0).
        load_settings(FULL_SCALE, '0, LEVEL_REG_MAX, '0, '0);
        paced_tick(1'b1);
        paced_tick(1'b1);
        paced_tick(1'b0);
        drain_results();

        // Smallest attack step, largest factors, a margin of 1/16 of full scale, sustain at zero.
        load_settings(CFG_DATA_W'(1), CFG_DATA_W'(MULT_MAX), '0, CFG_DATA_W'(MULT_MAX),
                      CFG_DATA_W'(MARGIN_MAX));
        repeat (3) paced_tick(1'b1);
        paced_tick(1'b0);
        drain_results();

        // Writes to undecoded indexes must be dropped; zero data would show up
        // as a stalled attack or instant decay if one aliased onto a register.
        for (int i = REG_SPARE_FIRST; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), '0);
        load_settings(FULL_SCALE >> 2, CFG_DATA_W'(MULT_HALF), FULL_SCALE >> 2,
                      CFG_DATA_W'(MULT_BRISK), CFG_DATA_W'(RST_MARGIN));
        // four attack ticks to full scale, then partway down the decay
        repeat (6) paced_tick(1'b1);
        drain_results();

        // Sustain raised mid-decay: the level now sits below sustain, climbs
        // toward it and finishes decay in the same tick.
        write_reg(REG_SUSTAIN, FULL_SCALE - (FULL_SCALE >> 4));
        close_cfg();
        paced_tick(1'b1);
        paced_tick(1'b0);           // release from sustain
        paced_tick(1'b1);           // retrigger: attack from the current level
        paced_tick(1'b1);           // reaches full scale, into decay
        paced_tick(1'b1);
        paced_tick(1'b0);           // decay step and release in one tick

        // Random part: each segment runs under its own register set.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            drain_results();
            if ($urandom_range(0, 7) == 0)
                sus_pick = CFG_DATA_W'($urandom_range(LEVEL_REG_MAX, FULL_SCALE + 1));
            else
                sus_pick = pick_setting('0, FULL_SCALE, '0, FULL_SCALE);
            load_settings(pick_setting(CFG_DATA_W'(1), FULL_SCALE, FULL_SCALE >> 5,
                                       FULL_SCALE),
                          pick_setting('0, CFG_DATA_W'(MULT_MAX), '0,
                                       CFG_DATA_W'(MULT_FAST_TOP)),
                          sus_pick,
                          pick_setting('0, CFG_DATA_W'(MULT_MAX), '0,
                                       CFG_DATA_W'(MULT_FAST_TOP)),
                          pick_setting('0, CFG_DATA_W'(MARGIN_MAX), '0,
                                       CFG_DATA_W'(MARGIN_MAX)));
            // every third segment runs the sender flat out
            pacing_on  = (seg % 3 != 2);
            burst_left = 0;
            random_segment(SEGMENT_TICKS);
        end

        drain_results();
        envelope_sb.count_leftovers();
        $display("Covered %0d ticks over %0d register sets, %0d envelope points compared.",
                 envelope_sb.ticks_noted, settings_run, envelope_sb.points_checked);
        $display("Ticks ending in attack %0d, decay %0d, sustain %0d, release %0d, stopped %0d;"
                 , envelope_sb.phase_hits[PH_ATTACK], envelope_sb.phase_hits[PH_DECAY],
                 envelope_sb.phase_hits[PH_SUSTAIN], envelope_sb.phase_hits[PH_RELEASE],
                 envelope_sb.phase_hits[PH_STOPPED]);
        if (envelope_sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", envelope_sb.mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
